/* rtl/dmr_pkg.sv */
// shared types and constants for the dissimilarity metric repair block
// depends on nothing; used by the top level and its checker

package dmr_pkg;

    // command codes carried by i_command
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EARLY = 1'b1;

    // configuration register word indexes
    localparam logic REG_MATRIX_SIZE = 1'b0;

    // field widths
    localparam int SIZE_W = 5;
    localparam int POS_W  = 8;
    localparam int VIOL_W = 33;

    // signed q16.16 value
    typedef logic signed [31:0] t_q16;

    localparam t_q16 Q_MAX = 32'sh7FFF_FFFF;

endpackage

/* rtl/dissimilarity_metric_repair.sv */
// top level of the dissimilarity metric repair block: entry store, load and read
// paths, triple scan sequencer and apb register; uses dmr_pkg

// Loads and reads are taken one per cycle while busy is low; each read gives its result
// on o_valid through the r_rq_valid and o_valid registers, and the receiver cannot hold
// it off. The last load of an n x n matrix starts the triangle scan, during which busy
// stays high: for n of 3 or more a single compare unit sees one triple per cycle
// through the two read ports of the entry store, after a fetch of each row/column
// pair; for n below 3 busy covers only the S_VIOL and S_SUM states. Sizes above
// MAX_SIZE act as MAX_SIZE; size zero ignores loads and answers reads as early.
module dissimilarity_metric_repair #(
    parameter int MAX_SIZE = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_command,
    input  logic signed [31:0]           i_entry_in,
    // result channel
    output logic                         o_valid,
    output logic signed [31:0]           o_entry_out,
    output logic [dmr_pkg::POS_W-1:0]    o_entry_position,
    output logic [31:0]                  o_shift_constant,
    output logic [dmr_pkg::VIOL_W-1:0]   o_violation_constant,
    output logic                         o_last_entry,
    output logic                         o_status,
    // apb register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_SIZE);
    localparam int NW    = $clog2(MAX_SIZE + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAIR,
        S_TRIP,
        S_DRAIN,
        S_VIOL,
        S_SUM
    } t_state;

    typedef enum logic {
        PH_LOADING,
        PH_READY
    } t_phase;

    // entry store
    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [AW-1:0]      mem_ra_a;
    logic [AW-1:0]      mem_ra_b;

    // control and matrix state
    t_state                      r_state;
    t_phase                      r_phase;
    logic [dmr_pkg::SIZE_W-1:0]  r_size;
    logic [AW-1:0]               r_ld_pos;
    logic [CW-1:0]               r_ld_row;
    logic [CW-1:0]               r_ld_col;
    logic [AW-1:0]               r_rd_pos;
    logic [CW-1:0]               r_rd_row;
    logic [CW-1:0]               r_rd_col;
    dmr_pkg::t_q16               r_least;
    logic [33:0]                 r_worst;
    logic [33:0]                 r_addc;

    // scan sequencer and pipeline
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_l;
    logic [CW-1:0]      r_j;
    logic [1:0]         r_drain;
    logic               r_s1_il;
    logic               r_s1_trip;
    logic signed [31:0] r_dil;
    logic signed [34:0] r_e;
    logic               r_s2_valid;
    logic signed [34:0] r_max;
    logic               r_any;

    // read request pipeline
    logic               r_rq_valid;
    logic               r_rq_early;
    logic               r_rq_diag;
    logic               r_rq_last;
    logic [AW-1:0]      r_rq_pos;

    logic [NW-1:0]      n_eff;
    logic [CW-1:0]      n_max;
    logic               accept;
    logic               do_load;
    logic               do_read;
    logic               cfg_wr;
    logic               ready_ph;
    logic [CW-1:0]      ld_row;
    logic [CW-1:0]      ld_col;
    logic [AW-1:0]      ld_pos;
    dmr_pkg::t_q16      least_base;
    logic [31:0]        sh;
    logic signed [32:0] neg_least;
    logic signed [34:0] e_next;
    logic signed [35:0] viol_diff;
    logic signed [34:0] adj_sum;
    logic signed [31:0] adj_entry;
    logic [31:0]        pos_wide;
    logic               trip_ok;
    logic               pair_last;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] row,
                                              input logic [CW-1:0] col,
                                              input logic [NW-1:0] n);
        return AW'(row) + AW'(AW'(col) * AW'(n));
    endfunction

    // size in use, clamped to the store
    always_comb begin
        if (32'(r_size) > MAX_SIZE) begin
            n_eff = NW'(MAX_SIZE);
        end else begin
            n_eff = NW'(r_size);
        end
    end
    assign n_max = CW'(n_eff - NW'(1));

    // handshakes
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign do_load  = accept && (i_command == dmr_pkg::CMD_LOAD) && (n_eff != '0);
    assign do_read  = accept && (i_command == dmr_pkg::CMD_READ);
    assign cfg_wr   = psel && penable && pwrite && pready
                      && (paddr[2] == dmr_pkg::REG_MATRIX_SIZE);
    assign ready_ph = (r_phase == PH_READY);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == dmr_pkg::REG_MATRIX_SIZE) ? 32'(r_size) : '0;

    // a load after completion restarts at position zero
    assign ld_row     = ready_ph ? '0 : r_ld_row;
    assign ld_col     = ready_ph ? '0 : r_ld_col;
    assign ld_pos     = ready_ph ? '0 : r_ld_pos;
    assign least_base = ready_ph ? dmr_pkg::Q_MAX : r_least;

    // positivity shift from the least off-diagonal entry
    assign neg_least = -33'(r_least);
    assign sh        = r_least[31] ? neg_least[31:0] : '0;

    // store ports
    assign mem_we   = do_load;
    assign mem_wa   = ld_pos;
    assign mem_ra_b = addr_of(r_j, r_l, n_eff);
    always_comb begin
        unique case (r_state)
            S_PAIR:  mem_ra_a = addr_of(r_i, r_l, n_eff);
            S_TRIP:  mem_ra_a = addr_of(r_i, r_j, n_eff);
            default: mem_ra_a = r_rd_pos;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= i_entry_in;
        end
        r_rd_a <= mem[mem_ra_a];
        r_rd_b <= mem[mem_ra_b];
    end

    // scan datapath
    assign trip_ok   = (r_j != r_i) && (r_j != r_l);
    assign pair_last = (r_i == n_max) && (r_l == n_max);
    assign e_next    = 35'(r_dil) - 35'(r_rd_a) - 35'(r_rd_b);
    assign viol_diff = 36'(r_max) - $signed({4'b0, sh});

    // read adjustment with saturation
    assign adj_sum = 35'(r_rd_a) + $signed({1'b0, r_addc});
    always_comb begin
        if (r_rq_diag) begin
            adj_entry = r_rd_a;
        end else if (adj_sum > 35'(dmr_pkg::Q_MAX)) begin
            adj_entry = dmr_pkg::Q_MAX;
        end else begin
            adj_entry = adj_sum[31:0];
        end
    end
    assign pos_wide = 32'(r_rq_pos);

    // sequencer, matrix state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_LOADING;
            r_size     <= '0;
            r_ld_pos   <= '0;
            r_ld_row   <= '0;
            r_ld_col   <= '0;
            r_rd_pos   <= '0;
            r_rd_row   <= '0;
            r_rd_col   <= '0;
            r_least    <= dmr_pkg::Q_MAX;
            r_worst    <= '0;
            r_addc     <= '0;
            r_s1_il    <= 1'b0;
            r_s1_trip  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_any      <= 1'b0;
            r_rq_valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            // scan pipeline defaults
            r_s1_il    <= 1'b0;
            r_s1_trip  <= 1'b0;
            r_s2_valid <= r_s1_trip;
            r_rq_valid <= 1'b0;
            o_valid    <= r_rq_valid;

            if (r_s1_il) begin
                r_dil <= r_rd_a;
            end
            r_e <= e_next;
            if (r_s2_valid && (!r_any || (r_e > r_max))) begin
                r_max <= r_e;
            end
            if (r_s2_valid) begin
                r_any <= 1'b1;
            end

            // result stage
            if (r_rq_valid) begin
                if (r_rq_early) begin
                    o_entry_out          <= '0;
                    o_entry_position     <= '0;
                    o_shift_constant     <= '0;
                    o_violation_constant <= '0;
                    o_last_entry         <= 1'b0;
                    o_status             <= dmr_pkg::STATUS_EARLY;
                end else begin
                    o_entry_out          <= adj_entry;
                    o_entry_position     <= pos_wide[dmr_pkg::POS_W-1:0];
                    o_shift_constant     <= sh;
                    o_violation_constant <= r_worst[dmr_pkg::VIOL_W-1:0];
                    o_last_entry         <= r_rq_last;
                    o_status             <= dmr_pkg::STATUS_OK;
                end
            end

            // configuration write restarts loading
            if (cfg_wr) begin
                r_size   <= pwdata[dmr_pkg::SIZE_W-1:0];
                r_phase  <= PH_LOADING;
                r_ld_pos <= '0;
                r_ld_row <= '0;
                r_ld_col <= '0;
                r_rd_pos <= '0;
                r_rd_row <= '0;
                r_rd_col <= '0;
                r_least  <= dmr_pkg::Q_MAX;
                r_worst  <= '0;
                r_addc   <= '0;
            end

            // read item
            if (do_read) begin
                r_rq_valid <= 1'b1;
                r_rq_early <= !ready_ph || (n_eff == '0);
                r_rq_diag  <= (r_rd_row == r_rd_col);
                r_rq_last  <= (r_rd_row == n_max) && (r_rd_col == n_max);
                r_rq_pos   <= r_rd_pos;
                if (ready_ph && (n_eff != '0)) begin
                    if ((r_rd_row == n_max) && (r_rd_col == n_max)) begin
                        r_rd_pos <= '0;
                        r_rd_row <= '0;
                        r_rd_col <= '0;
                    end else if (r_rd_row == n_max) begin
                        r_rd_pos <= r_rd_pos + AW'(1);
                        r_rd_row <= '0;
                        r_rd_col <= r_rd_col + CW'(1);
                    end else begin
                        r_rd_pos <= r_rd_pos + AW'(1);
                        r_rd_row <= r_rd_row + CW'(1);
                    end
                end
            end

            // load item
            if (do_load) begin
                r_phase  <= PH_LOADING;
                r_rd_pos <= '0;
                r_rd_row <= '0;
                r_rd_col <= '0;
                if ((ld_row != ld_col) && (i_entry_in < least_base)) begin
                    r_least <= i_entry_in;
                end else begin
                    r_least <= least_base;
                end
                r_ld_pos <= ld_pos + AW'(1);
                if (ld_row == n_max) begin
                    r_ld_row <= '0;
                    r_ld_col <= ld_col + CW'(1);
                end else begin
                    r_ld_row <= ld_row + CW'(1);
                    r_ld_col <= ld_col;
                end
                // last entry starts the triangle scan, or for n below 3 the violation step
                if ((ld_row == n_max) && (ld_col == n_max)) begin
                    r_i   <= '0;
                    r_l   <= '0;
                    r_j   <= '0;
                    r_any <= 1'b0;
                    if (n_eff >= NW'(3)) begin
                        r_state <= S_PAIR;
                    end else begin
                        r_state <= S_VIOL;
                    end
                end
            end

            // triple scan sequencer
            unique case (r_state)
                S_IDLE: begin
                end
                S_PAIR: begin
                    if (r_i != r_l) begin
                        r_s1_il <= 1'b1;
                        r_j     <= '0;
                        r_state <= S_TRIP;
                    end else if (pair_last) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end else if (r_i == n_max) begin
                        r_i <= '0;
                        r_l <= r_l + CW'(1);
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_TRIP: begin
                    r_s1_trip <= trip_ok;
                    if (r_j != n_max) begin
                        r_j <= r_j + CW'(1);
                    end else if (pair_last) begin
                        r_drain <= '0;
                        r_state <= S_DRAIN;
                    end else if (r_i == n_max) begin
                        r_i     <= '0;
                        r_l     <= r_l + CW'(1);
                        r_state <= S_PAIR;
                    end else begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_PAIR;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 2'd1;
                    if (r_drain == 2'd2) begin
                        r_state <= S_VIOL;
                    end
                end
                S_VIOL: begin
                    if (r_any && (viol_diff > 36'sd0)) begin
                        r_worst <= viol_diff[33:0];
                    end else begin
                        r_worst <= '0;
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_addc  <= 34'(sh) + r_worst;
                    r_phase <= PH_READY;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/dmr_chk.sv */
// port-level checker for the dissimilarity metric repair block, with its bind
// depends on dmr_pkg and the top level dissimilarity_metric_repair

module dmr_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_command,
    input logic                       o_valid,
    input logic signed [31:0]         o_entry_out,
    input logic [dmr_pkg::POS_W-1:0]  o_entry_position,
    input logic [31:0]                o_shift_constant,
    input logic [dmr_pkg::VIOL_W-1:0] o_violation_constant,
    input logic                       o_last_entry,
    input logic                       o_status
);

    // every result comes from a read item taken by the block, via the request and result registers
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && (i_command == dmr_pkg::CMD_READ), 2))
        else $error("result without a read item");

    // an early read reports nothing but its status
    a_early_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == dmr_pkg::STATUS_EARLY)) |->
            (o_entry_out == '0) && (o_entry_position == '0) && (o_shift_constant == '0)
            && (o_violation_constant == '0) && !o_last_entry)
        else $error("early read carries data");

    // the scan only starts after a load item
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_command == dmr_pkg::CMD_LOAD)))
        else $error("scan started without a load");

    // back-to-back valid reads report the same constants
    a_constants_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(o_valid) && (o_status == dmr_pkg::STATUS_OK)
            && ($past(o_status) == dmr_pkg::STATUS_OK)) |->
            ($stable(o_shift_constant) && $stable(o_violation_constant)))
        else $error("constants changed between reads");

endmodule

bind dissimilarity_metric_repair dmr_chk u_dmr_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .i_command           (i_command),
    .o_valid             (o_valid),
    .o_entry_out         (o_entry_out),
    .o_entry_position    (o_entry_position),
    .o_shift_constant    (o_shift_constant),
    .o_violation_constant(o_violation_constant),
    .o_last_entry        (o_last_entry),
    .o_status            (o_status)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// self-checking bench for dissimilarity_metric_repair: apb size writes, load and read items
// depends on dmr_pkg and the block's top level; scoreboard class predicts every readout

module tb;
    import dmr_pkg::*;

    localparam int MAX_N        = 16;
    localparam int ITEM_TARGET  = 1650;
    localparam int GAP_MAX      = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int REPORT_LIMIT = 10;

    // one readout as it leaves the block
    typedef struct packed {
        t_q16              value;
        logic [POS_W-1:0]  position;
        logic [31:0]       shift;
        logic [VIOL_W-1:0] violation;
        logic              last;
        logic              status;
    } t_matrix_readout;

    // matrix store, repair constants and the readouts still owed by the block
    class repair_scoreboard;
        t_q16            entries [MAX_N*MAX_N];
        int unsigned     size_reg;
        int unsigned     load_count;
        int unsigned     read_pos;
        t_q16            least_off;
        longint          worst_gap;
        bit              ready;
        t_matrix_readout owed_readouts [$];
        int              mismatches;

        function new();
            size_reg   = 0;
            mismatches = 0;
            restart_matrix();
        endfunction

        function int unsigned active_n();
            return (size_reg > MAX_N) ? MAX_N : size_reg;
        endfunction

        function int unsigned outstanding();
            return owed_readouts.size();
        endfunction

        function void restart_matrix();
            load_count = 0;
            read_pos   = 0;
            least_off  = Q_MAX;
            worst_gap  = 0;
            ready      = 1'b0;
        endfunction

        function void write_size(logic [SIZE_W-1:0] sz);
            size_reg = 32'(sz);
            restart_matrix();
        endfunction

        function longint shift_amount();
            return (least_off < 0) ? -longint'(least_off) : 64'sd0;
        endfunction

        // largest triangle violation over distinct triples of shifted entries
        function void scan_triangles(int unsigned n);
            longint sh;
            longint worst;
            longint gap;
            sh    = shift_amount();
            worst = 0;
            for (int unsigned i = 0; i < n; i++)
                for (int unsigned j = 0; j < n; j++)
                    for (int unsigned l = 0; l < n; l++) begin
                        if (i == j || j == l || i == l)
                            continue;
                        gap = (longint'(entries[i + l*n]) + sh)
                            - (longint'(entries[i + j*n]) + sh)
                            - (longint'(entries[j + l*n]) + sh);
                        if (gap > worst)
                            worst = gap;
                    end
            worst_gap = worst;
        endfunction

        // accepted item: update the matrix or queue the readout it causes
        function void note_command(logic cmd, t_q16 value);
            int unsigned     n;
            int unsigned     total;
            int unsigned     p;
            longint          adj;
            t_matrix_readout r;
            n     = active_n();
            total = n * n;
            if (cmd == CMD_LOAD) begin
                if (total == 0)
                    return;
                if (ready)
                    restart_matrix();
                if (load_count >= total)
                    return;
                p = load_count;
                entries[p] = value;
                if ((p % n) != (p / n) && value < least_off)
                    least_off = value;
                load_count = p + 1;
                if (load_count == total) begin
                    scan_triangles(n);
                    ready = 1'b1;
                end
                return;
            end
            r = '0;
            if (!ready || total == 0 || read_pos >= total) begin
                r.status = STATUS_EARLY;
                owed_readouts.push_back(r);
                return;
            end
            p   = read_pos;
            adj = longint'(entries[p]);
            // off-diagonal entries get both constants, saturated high
            if ((p % n) != (p / n)) begin
                adj = adj + shift_amount() + worst_gap;
                if (adj > longint'(Q_MAX))
                    adj = longint'(Q_MAX);
            end
            r.value     = adj[31:0];
            r.position  = POS_W'(p);
            r.shift     = 32'(shift_amount());
            r.violation = VIOL_W'(worst_gap);
            r.last      = (p == total - 1);
            r.status    = STATUS_OK;
            read_pos    = r.last ? 0 : p + 1;
            owed_readouts.push_back(r);
        endfunction

        function void check_readout(t_matrix_readout got);
            t_matrix_readout want;
            if (owed_readouts.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected readout: value %h pos %0d status %b",
                             got.value, got.position, got.status);
                return;
            end
            want = owed_readouts.pop_front();
            if (got.value !== want.value || got.position !== want.position ||
                got.shift !== want.shift || got.violation !== want.violation ||
                got.last !== want.last || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("mismatch expected: value %h pos %0d sh %h viol %h last %b st %b",
                             want.value, want.position, want.shift, want.violation,
                             want.last, want.status);
                    $display("         actual:   value %h pos %0d sh %h viol %h last %b st %b",
                             got.value, got.position, got.shift, got.violation,
                             got.last, got.status);
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_command;
    t_q16                i_entry_in;
    logic                o_valid;
    t_q16                o_entry_out;
    logic [POS_W-1:0]    o_entry_position;
    logic [31:0]         o_shift_constant;
    logic [VIOL_W-1:0]   o_violation_constant;
    logic                o_last_entry;
    logic                o_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    repair_scoreboard    sb = new();
    int unsigned         items_sent = 0;
    int unsigned         gap_cap = 0;
    int                  cycle_count = 0;

    dissimilarity_metric_repair #(
        .MAX_SIZE(MAX_N)
    ) u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_command            (i_command),
        .i_entry_in           (i_entry_in),
        .o_valid              (o_valid),
        .o_entry_out          (o_entry_out),
        .o_entry_position     (o_entry_position),
        .o_shift_constant     (o_shift_constant),
        .o_violation_constant (o_violation_constant),
        .o_last_entry         (o_last_entry),
        .o_status             (o_status),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_readout({o_entry_out, o_entry_position, o_shift_constant,
                              o_violation_constant, o_last_entry, o_status});
    end

    // one item: random gap, then hold start until the block takes it
    task automatic issue(logic cmd, t_q16 value);
        int unsigned gap;
        gap = $urandom_range(0, gap_cap);
        repeat (gap) begin
            @(negedge i_clk);
            start      = 1'b0;
            i_command  = 1'($urandom);
            i_entry_in = $urandom;
        end
        @(negedge i_clk);
        start      = 1'b1;
        i_command  = cmd;
        i_entry_in = value;
        do @(posedge i_clk); while (busy);
        if (!(cmd == CMD_LOAD && sb.active_n() == 0))
            items_sent++;
        sb.note_command(cmd, value);
    endtask

    // sender pause until every owed readout has come
    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // idle block: readouts drained and any triple scan finished
    task automatic quiesce();
        int unsigned n;
        drain_results();
        n = sb.active_n();
        repeat (n * n * n + 16) @(posedge i_clk);
    endtask

    task automatic write_matrix_size(logic [SIZE_W-1:0] sz);
        quiesce();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_MATRIX_SIZE, 2'b00};
        pwdata  = 32'(sz);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_size(sz);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // entry values: full range, metric-like, mixed sign, or near the extremes
    function automatic t_q16 draw_entry(int unsigned style);
        if ($urandom_range(0, 31) == 0)
            return $urandom;
        case (style)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0010_0000);
            2: return t_q16'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX - $urandom_range(0, 255);
                    1: return 32'sh8000_0000 + $urandom_range(0, 255);
                    2: return '0;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return SIZE_W'(0);
        else if (roll < 8)
            return SIZE_W'(1);
        else if (roll < 80)
            return SIZE_W'($urandom_range(2, 6));
        else if (roll < 90)
            return SIZE_W'($urandom_range(7, 9));
        else if (roll < 96)
            return SIZE_W'($urandom_range(10, 15));
        else if (roll < 98)
            return SIZE_W'(16);
        return SIZE_W'($urandom_range(17, 31));
    endfunction

    task automatic directed_checks();
        t_q16 corner [9] = '{Q_MAX, 32'sh8000_0000, Q_MAX,
                             32'sh0001_0000, -32'sd1, Q_MAX,
                             32'sh0000_0000, 32'sh7FFF_0000, 32'sh0000_0000};
        gap_cap = 0;
        // size zero after reset: loads ignored, reads early
        issue(CMD_READ, '0);
        issue(CMD_LOAD, Q_MAX);
        issue(CMD_READ, '0);
        // size one: lone diagonal entry, no constants, reads wrap
        write_matrix_size(5'd1);
        issue(CMD_LOAD, 32'sh8000_0000);
        issue(CMD_READ, '0);
        issue(CMD_READ, '1);
        // size three at the extremes: full shift, large violation, saturation
        write_matrix_size(5'd3);
        foreach (corner[k]) begin
            if (k == 4)
                issue(CMD_READ, '0);
            issue(CMD_LOAD, corner[k]);
        end
        drain_results();
        repeat (10) issue(CMD_READ, '1);
        // load after completion begins a new matrix
        issue(CMD_LOAD, '0);
        issue(CMD_READ, '0);
    endtask

    // one size setting: well-formed matrices with random content, some broken
    task automatic run_phase(logic [SIZE_W-1:0] sz, bit read_all);
        int unsigned n;
        int unsigned total;
        int unsigned loads;
        int unsigned reads;
        int unsigned style;
        int unsigned rounds;
        write_matrix_size(sz);
        n       = sb.active_n();
        total   = n * n;
        gap_cap = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
        if (n == 0) begin
            repeat ($urandom_range(3, 8)) issue(1'($urandom), $urandom);
            return;
        end
        rounds = (n >= 10) ? 1 : $urandom_range(1, 4);
        repeat (rounds) begin
            if (items_sent >= ITEM_TARGET)
                break;
            style = $urandom_range(0, 3);
            loads = total;
            if (!read_all && n > 1 && $urandom_range(0, 9) == 0)
                loads = $urandom_range(1, total - 1);
            repeat (loads) begin
                if ($urandom_range(0, 24) == 0)
                    issue(CMD_READ, $urandom);
                issue(CMD_LOAD, draw_entry(style));
            end
            if ($urandom_range(0, 29) == 0)
                drain_results();
            case ($urandom_range(0, 3))
                0: reads = total;
                1: reads = total + $urandom_range(1, (n >= 10) ? n : total);
                2: reads = $urandom_range(1, total);
                default: reads = 0;
            endcase
            if (read_all)
                reads = total + 2;
            repeat (reads) begin
                if ($urandom_range(0, 63) == 0)
                    drain_results();
                issue(CMD_READ, $urandom);
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_command  = CMD_LOAD;
        i_entry_in = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_checks();

        // largest register value acts as the largest size: one full matrix
        run_phase(5'd31, 1'b1);
        // size write in the middle of loading restarts the matrix
        write_matrix_size(5'd16);
        gap_cap = GAP_MAX;
        repeat (30) issue(CMD_LOAD, draw_entry(0));
        issue(CMD_READ, '0);

        while (items_sent < ITEM_TARGET)
            run_phase(pick_size(), 1'b0);

        quiesce();
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
